[hw/rtl/fdd_pkg.sv]
`default_nettype none
// ============================================================================
// fdd_pkg : shared types and constants of the finite difference derivative
// Beat structs, config register codes, derivative methods and the entry
// passed from the window stage to the scaling pipeline.
// ============================================================================
package fdd_pkg;

    localparam int SAMPLE_W = 24;
    localparam int SLOPE_W  = 32;
    localparam int POS_W    = 16;
    localparam int RECIP_W  = 32;
    localparam int DIFF_W   = 29;   // -f0 + 8(f1-f3) + f4 fits in 29 signed bits
    localparam int PROD_W   = 61;   // 29 signed x 33 signed
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int JOB_N    = 3;    // at most three results per sample

    localparam logic [RECIP_W-1:0] RECIP_RESET = 32'h0001_0000;

    typedef enum logic [1:0] {
        REG_METHOD       = 2'd0,
        REG_RECIP_STEP   = 2'd1,
        REG_RECIP_TWO    = 2'd2,
        REG_RECIP_TWELVE = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        METH_FWD  = 2'd0,
        METH_BWD  = 2'd1,
        METH_CTR  = 2'd2,
        METH_FIVE = 2'd3
    } t_method;

    typedef enum logic [1:0] {
        RSEL_STEP   = 2'd0,
        RSEL_TWO    = 2'd1,
        RSEL_TWELVE = 2'd2
    } t_rsel;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       final_req;
    } t_in_beat;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        logic [POS_W-1:0]          position;
        logic                      tail;
        logic                      fault;
    } t_out_beat;

    typedef struct packed {
        t_method            method;
        logic [RECIP_W-1:0] recip_step;
        logic [RECIP_W-1:0] recip_two_step;
        logic [RECIP_W-1:0] recip_twelve_step;
    } t_cfg;

    // one pending result: difference combination and which reciprocal scales it
    typedef struct packed {
        logic signed [DIFF_W-1:0] diff;
        t_rsel                    rsel;
        logic [POS_W-1:0]         pos;
        logic                     tail;
        logic                     fault;
    } t_term;

    // request into the multiplier stage
    typedef struct packed {
        logic signed [DIFF_W-1:0] diff;
        logic [RECIP_W-1:0]       recip;
        logic [POS_W-1:0]         pos;
        logic                     tail;
        logic                     fault;
    } t_mul_req;

endpackage
`default_nettype wire

[hw/rtl/fdd_cfg.sv]
`default_nettype none
// ============================================================================
// fdd_cfg : APB register file
// Method select and the three reciprocal step registers.
// ============================================================================
module fdd_cfg import fdd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.method            <= METH_FWD;
            r_cfg.recip_step        <= RECIP_RESET;
            r_cfg.recip_two_step    <= RECIP_RESET;
            r_cfg.recip_twelve_step <= RECIP_RESET;
        end else if (wr_en) begin
            unique case (idx)
                REG_METHOD:       r_cfg.method            <= t_method'(pwdata[1:0]);
                REG_RECIP_STEP:   r_cfg.recip_step        <= pwdata;
                REG_RECIP_TWO:    r_cfg.recip_two_step    <= pwdata;
                REG_RECIP_TWELVE: r_cfg.recip_twelve_step <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_METHOD:       prdata = DATA_W'(r_cfg.method);
            REG_RECIP_STEP:   prdata = r_cfg.recip_step;
            REG_RECIP_TWO:    prdata = r_cfg.recip_two_step;
            REG_RECIP_TWELVE: prdata = r_cfg.recip_twelve_step;
            default:          prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/fdd_window.sv]
`default_nettype none
// ============================================================================
// fdd_window : sample window, index counter and result job register
// Forms the difference terms for each sample and hands them out one beat
// at a time to the scaling pipeline.
// ============================================================================
module fdd_window import fdd_pkg::*; #(
    parameter int MAX_LEN = 65536
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire t_in_beat i_in,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output t_mul_req      o_req,
    output logic          o_req_valid,
    input  wire logic     i_req_ready
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic signed [SAMPLE_W-1:0] r_win [4];   // f[k-1] .. f[k-4]
    logic [CW-1:0]              r_count;
    t_term                      r_job [JOB_N];
    logic [1:0]                 r_jn;
    logic [1:0]                 r_sel;
    logic                       r_job_valid;

    logic                       accept, issue, last_issue, last;
    logic signed [SAMPLE_W-1:0] w0, w1, w2, w3, w4;
    logic signed [DIFF_W-1:0]   d01, d10, d21, d02, d13, d5;
    logic [PW-1:0]              kx;
    logic                       k_ge2, k_lt4, k_is2, k_is3, is_short;
    t_term                      t_lag, t_a, t_b;
    t_term                      n_job [JOB_N];
    logic [1:0]                 n_jn;
    t_term                      cur;

    assign w0 = i_in.sample;
    assign w1 = r_win[0];
    assign w2 = r_win[1];
    assign w3 = r_win[2];
    assign w4 = r_win[3];

    assign d01 = DIFF_W'(w0) - DIFF_W'(w1);
    assign d10 = DIFF_W'(w1) - DIFF_W'(w2);
    assign d21 = DIFF_W'(w2) - DIFF_W'(w3);
    assign d02 = DIFF_W'(w0) - DIFF_W'(w2);
    assign d13 = DIFF_W'(w1) - DIFF_W'(w3);
    assign d5  = DIFF_W'(w4) - DIFF_W'(w0) + (d13 <<< 3);

    assign last     = i_in.final_req;
    assign kx       = PW'(r_count);
    assign k_ge2    = (r_count >= CW'(2));
    assign k_lt4    = (r_count < CW'(4));
    assign k_is2    = (r_count == CW'(2));
    assign k_is3    = (r_count == CW'(3));
    assign is_short = last && k_lt4;

    // lagged estimate for index k-2, plus the two end terms on the last sample
    always_comb begin
        t_lag.pos   = POS_W'(kx - PW'(2));
        t_lag.tail  = 1'b0;
        t_lag.fault = 1'b0;
        t_lag.diff  = d10;
        t_lag.rsel  = RSEL_STEP;
        unique case (i_cfg.method)
            METH_FWD: ;
            METH_BWD: begin
                if (!k_is2) t_lag.diff = d21;
            end
            METH_CTR: begin
                if (!k_is2) begin
                    t_lag.diff = d13;
                    t_lag.rsel = RSEL_TWO;
                end
            end
            METH_FIVE: begin
                if (k_is3) begin
                    t_lag.diff = d13;
                    t_lag.rsel = RSEL_TWO;
                end else if (!k_is2) begin
                    t_lag.diff = d5;
                    t_lag.rsel = RSEL_TWELVE;
                end
            end
            default: ;
        endcase

        t_a.pos   = POS_W'(kx - PW'(1));
        t_a.tail  = 1'b0;
        t_a.fault = 1'b0;
        t_b.pos   = POS_W'(kx);
        t_b.tail  = 1'b1;
        t_b.fault = 1'b0;
        unique case (i_cfg.method)
            METH_FWD: begin
                t_a.diff = d01;
                t_a.rsel = RSEL_STEP;
            end
            METH_BWD: begin
                t_a.diff = d10;
                t_a.rsel = RSEL_STEP;
            end
            default: begin
                t_a.diff = d02;
                t_a.rsel = RSEL_TWO;
            end
        endcase
        // forward method repeats the previous slope at the last index
        if (i_cfg.method == METH_FWD) begin
            t_b.diff = t_a.diff;
            t_b.rsel = t_a.rsel;
        end else begin
            t_b.diff = d01;
            t_b.rsel = RSEL_STEP;
        end
    end

    always_comb begin
        n_job[0] = t_lag;
        n_job[1] = t_a;
        n_job[2] = t_b;
        n_jn     = 2'd0;
        if (is_short) begin
            n_job[0].diff  = '0;
            n_job[0].rsel  = RSEL_STEP;
            n_job[0].pos   = POS_W'(kx);
            n_job[0].tail  = 1'b1;
            n_job[0].fault = 1'b1;
            n_jn           = 2'd1;
        end else if (k_ge2) begin
            n_jn = last ? 2'd3 : 2'd1;
        end
    end

    assign cur        = r_job[r_sel];
    assign issue      = r_job_valid && i_req_ready;
    assign last_issue = issue && (r_sel == r_jn - 2'd1);
    assign o_in_ready = !r_job_valid || last_issue;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_req.diff  = cur.diff;
        o_req.pos   = cur.pos;
        o_req.tail  = cur.tail;
        o_req.fault = cur.fault;
        unique case (cur.rsel)
            RSEL_STEP:   o_req.recip = i_cfg.recip_step;
            RSEL_TWO:    o_req.recip = i_cfg.recip_two_step;
            RSEL_TWELVE: o_req.recip = i_cfg.recip_twelve_step;
            default:     o_req.recip = i_cfg.recip_step;
        endcase
    end
    assign o_req_valid = r_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_job_valid <= 1'b0;
            r_sel       <= '0;
            r_jn        <= '0;
            for (int i = 0; i < 4; i++) r_win[i] <= '0;
        end else begin
            if (accept) begin
                if (last) begin
                    r_count <= '0;
                    for (int i = 0; i < 4; i++) r_win[i] <= '0;
                end else begin
                    if (r_count < CW'(MAX_LEN)) r_count <= r_count + CW'(1);
                    r_win[0] <= w0;
                    for (int i = 1; i < 4; i++) r_win[i] <= r_win[i-1];
                end
            end
            if (accept && (n_jn != 2'd0)) begin
                r_job_valid <= 1'b1;
                r_jn        <= n_jn;
                r_sel       <= '0;
            end else if (last_issue) begin
                r_job_valid <= 1'b0;
            end else if (issue) begin
                r_sel <= r_sel + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < JOB_N; i++) r_job[i] <= n_job[i];
        end
    end

endmodule
`default_nettype wire

[hw/rtl/fdd_scale.sv]
`default_nettype none
// ============================================================================
// fdd_scale : reciprocal multiply, round and saturate
// Product register, then round half up to Q10.21 and clamp into the
// output register.
// ============================================================================
module fdd_scale import fdd_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    input  wire logic     i_req_valid,
    output logic          o_req_ready,
    output t_out_beat     o_out,
    output logic          o_out_valid,
    input  wire logic     i_out_ready
);

    logic signed [PROD_W-1:0] r_prod;
    logic [POS_W-1:0]         r_pos;
    logic                     r_tail, r_fault, r_pv;
    t_out_beat                r_out;
    logic                     r_ov;

    logic                     s2_ready;
    logic signed [32:0]       recip_s;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W:0]   rnd;
    logic signed [45:0]       sh;
    logic signed [SLOPE_W-1:0] n_slope;

    assign s2_ready    = !r_ov || i_out_ready;
    assign o_req_ready = !r_pv || s2_ready;

    assign recip_s = $signed({1'b0, i_req.recip});
    assign n_prod  = i_req.diff * recip_s;

    assign rnd = (PROD_W+1)'(r_prod) + (PROD_W+1)'(32768);
    assign sh  = rnd[PROD_W:16];

    always_comb begin
        if ((&sh[45:31]) || !(|sh[45:31])) n_slope = sh[31:0];
        else if (sh[45])                   n_slope = 32'sh8000_0000;
        else                               n_slope = 32'sh7FFF_FFFF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (o_req_ready) r_pv <= i_req_valid;
            if (s2_ready)    r_ov <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_prod  <= n_prod;
            r_pos   <= i_req.pos;
            r_tail  <= i_req.tail;
            r_fault <= i_req.fault;
        end
        if (s2_ready && r_pv) begin
            r_out.slope    <= n_slope;
            r_out.position <= r_pos;
            r_out.tail     <= r_tail;
            r_out.fault    <= r_fault;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_ov;

endmodule
`default_nettype wire

[hw/rtl/finite_difference_derivative.sv]
// Path: the first result of a sample goes from the job register to the
// product register and then to the output register.
// Throughput: one sample per cycle while no beat stalls; a final sample holds
// the job register until its up to three result beats issue, one per cycle.
// Reset: synchronous, active low; clears the window, index count, pipeline
// valids and restores the method and reciprocal registers to their defaults.
`default_nettype none
// ============================================================================
// finite_difference_derivative : streaming first-derivative estimator
// Evenly spaced samples in, one derivative beat per grid index out, using a
// forward, backward, central or five-point stencil chosen over APB.
// ============================================================================
module finite_difference_derivative import fdd_pkg::*; #(
    parameter int MAX_LEN = 65536     // index counter saturates here
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // sample stream
    input  wire t_in_beat          i_in,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    // derivative stream
    output t_out_beat              o_out,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    // APB configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    t_cfg     cfg;
    t_mul_req req;
    logic     req_valid, req_ready;

    // Register file: method plus three reciprocals (1/h, 1/2h, 1/12h, Q16.16).
    fdd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Window stage: the accepted sample and the four before it form the
    // stencil differences. Each sample from index 2 on yields the estimate
    // for index k-2; the final sample also yields the two end indices, and a
    // final sample below index 4 yields a single fault beat instead.
    // The job register holds those terms while they issue one per beat, so the
    // input stalls while a final sample's terms drain or a beat is not taken.
    fdd_window #(
        .MAX_LEN (MAX_LEN)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in        (i_in),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_req       (req),
        .o_req_valid (req_valid),
        .i_req_ready (req_ready)
    );

    // Scaling pipeline: difference times reciprocal is registered, then
    // rounded half up and clamped to 32 bits in the output register.
    // Each stage advances when the one after it is empty or draining, so a
    // held output beat does not stop the stages behind it from filling.
    fdd_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

endmodule
`default_nettype wire

[hw/rtl/fdd_checker.sv]
`default_nettype none
// ============================================================================
// fdd_checker : port-level checks for the derivative block
// Output beat hold under stall, fault beat shape, state right after reset.
// ============================================================================
module fdd_checker import fdd_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_beat o_out
);

    // a stalled result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result beat changed while stalled");

    // a short-sequence beat closes the sequence and carries a zero slope
    a_fault_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.fault) |-> (o_out.tail && (o_out.slope == '0)))
        else $error("fault beat without tail or with nonzero slope");

    // reset empties the pipeline and opens the input
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("pipeline not empty after reset");

endmodule

bind finite_difference_derivative fdd_checker u_fdd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
`default_nettype wire
